// File: rtl/jacobi_heat_stencil_sweep_core_defines.svh
// Assertion macros for the Jacobi heat stencil sweep core checker.
// Used by jhs_checker; no other dependencies.
`ifndef JACOBI_HEAT_STENCIL_SWEEP_CORE_DEFINES_SVH
`define JACOBI_HEAT_STENCIL_SWEEP_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define JHS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("jhs_checker: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define JHS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("jhs_checker: next-cycle check failed");

`endif

// File: rtl/jhs_pkg.sv
// Package for the Jacobi heat stencil sweep core: sizes, register codes,
// reset values and the structs passed between its modules. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package jhs_pkg;

  localparam int TEMP_BITS   = 24;
  localparam int MAX_COLUMNS = 1024;
  localparam int COL_W       = $clog2(MAX_COLUMNS);
  localparam int CNT_W       = COL_W + 1;
  localparam int ROW_W       = 16;

  localparam int COEF_W      = 15;
  localparam int THR_W       = 24;
  localparam int CFG_COLS_W  = 11;
  localparam int CFG_ROWS_W  = 16;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 24;

  localparam int FRAC_BITS   = 16;
  localparam int KC_W        = FRAC_BITS + 1;
  localparam int SUM_W       = TEMP_BITS + 2;
  localparam int P1_W        = SUM_W + COEF_W;
  localparam int P2_W        = TEMP_BITS + KC_W;
  localparam int ACC_W       = ((P1_W > P2_W) ? P1_W : P2_W) + 1;
  localparam int V_W         = ACC_W - FRAC_BITS;

  localparam logic [CFG_IDX_W-1:0] REG_COEFF  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_THRESH = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_COLS   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_ROWS   = CFG_IDX_W'(3);

  localparam logic [COEF_W-1:0]     COEFF_RST  = COEF_W'(15729);
  localparam logic [THR_W-1:0]      THRESH_RST = THR_W'(66);
  localparam logic [CFG_COLS_W-1:0] COLS_RST   = CFG_COLS_W'(800);
  localparam logic [CFG_ROWS_W-1:0] ROWS_RST   = CFG_ROWS_W'(800);

  localparam logic [COEF_W-1:0]     COEFF_MAX  = COEF_W'(16384);
  localparam logic [CFG_COLS_W-1:0] COLS_MIN   = CFG_COLS_W'(3);
  localparam logic [CFG_COLS_W-1:0] COLS_MAX   = CFG_COLS_W'(MAX_COLUMNS);
  localparam logic [CFG_ROWS_W-1:0] ROWS_MIN   = CFG_ROWS_W'(3);

  localparam logic [KC_W-1:0]  KC_ONE     = KC_W'(1) << FRAC_BITS;
  localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (FRAC_BITS - 1);

  typedef logic [TEMP_BITS-1:0] temp_t;
  localparam temp_t TEMP_MAX = '1;

  typedef struct packed {
    logic [COEF_W-1:0] coeff;
    logic [THR_W-1:0]  thresh;
    logic [CNT_W-1:0]  cols;
    logic [ROW_W-1:0]  rows;
  } cfg_t;

  typedef struct packed {
    logic is_edge;
    logic start;
    logic last;
    logic emit;
  } flags_t;

  typedef struct packed {
    temp_t            temp;
    logic [COL_W-1:0] col;
    logic             col0;
    logic             last_col;
    flags_t           flags;
  } item_t;

  typedef struct packed {
    logic             load;
    logic             acc;
    logic [COL_W-1:0] col;
    logic [COL_W-1:0] right_addr;
    temp_t            temp;
  } lb_req_t;

  typedef struct packed {
    logic             en;
    logic [COL_W-1:0] addr;
    temp_t            data;
  } lb_wr_t;

  typedef struct packed {
    temp_t centre0;
    temp_t right;
    temp_t above2;
  } lb_rd_t;

  typedef struct packed {
    temp_t  val;
    temp_t  centre;
    flags_t flags;
  } res_t;

endpackage

`default_nettype wire

// File: rtl/jhs_channels.sv
// Channel interfaces of the Jacobi heat stencil sweep core: input cells,
// results and configuration writes. Depends on jhs_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface jhs_in_if;
  logic            valid;
  logic            ready;
  jhs_pkg::temp_t  cell_temp;
  logic            sweep_start;
  modport source (output valid, cell_temp, sweep_start, input ready);
  modport sink   (input valid, cell_temp, sweep_start, output ready);
endinterface

interface jhs_out_if;
  logic            valid;
  logic            ready;
  jhs_pkg::temp_t  new_temp;
  logic            sweep_last;
  jhs_pkg::temp_t  largest_change;
  logic            settled;
  modport source (output valid, new_temp, sweep_last, largest_change, settled, input ready);
  modport sink   (input valid, new_temp, sweep_last, largest_change, settled, output ready);
endinterface

interface jhs_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [jhs_pkg::CFG_IDX_W-1:0]      index;
  logic [jhs_pkg::CFG_DATA_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: rtl/jacobi_heat_stencil_sweep_core.sv
// Jacobi heat stencil sweep core, top level: raster counters, line stores,
// stencil pipe and change tracking. Depends on jhs_pkg, jhs_channels and
// the jhs_* modules.
//
// Usage:
//   in_ch   takes one old cell per transfer in raster order, Q8.16, with
//           sweep_start marking row 0, column 0 of a sweep.
//   out_ch  gives the updated cell one row above each input from row 1 on,
//           with the running maximum change; sweep_last and settled mark
//           the last result of the sweep. The bottom row is never emitted.
//   cfg_ch  writes coefficient, threshold, width and height; always ready.
//           Write only while no transfer is in flight.
// Throughput is one cell per cycle unless out_ch stalls. From the transfer of
// the cell that completes it, a result passes the line store read registers,
// then the sum, products and rounding stages, then the output register.
// A stall on out_ch holds the result and backs up the stages; in_ch stays
// ready as long as any stage can still move. Reset clears counters, window
// and maximum; the line stores start undefined and need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module jacobi_heat_stencil_sweep_core (
  input  logic      clk,
  input  logic      rst_n,
  jhs_in_if.sink    in_ch,
  jhs_out_if.source out_ch,
  jhs_cfg_if.sink   cfg_ch
);

  jhs_pkg::cfg_t              cfg;
  jhs_pkg::item_t             item;
  jhs_pkg::lb_req_t           lb_req;
  jhs_pkg::lb_wr_t            lb_wr;
  jhs_pkg::lb_rd_t            lb_rd;
  jhs_pkg::res_t              res;
  logic                       res_valid;
  logic                       in_load, in_acc, out_load;

  logic [jhs_pkg::COL_W-1:0]  col_r, col_nxt, col_cur;
  logic [jhs_pkg::ROW_W-1:0]  row_r, row_nxt, row_cur;
  logic                       last_col, last_row;

  jhs_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  assign col_cur  = in_ch.sweep_start ? '0 : col_r;
  assign row_cur  = in_ch.sweep_start ? '0 : row_r;
  assign last_col = (jhs_pkg::CNT_W'(col_cur) + jhs_pkg::CNT_W'(1)) >= cfg.cols;
  assign last_row = ((jhs_pkg::ROW_W + 1)'(row_cur) + (jhs_pkg::ROW_W + 1)'(1))
                    >= (jhs_pkg::ROW_W + 1)'(cfg.rows);

  assign in_ch.ready = in_load;
  assign in_acc      = in_ch.valid && in_load;

  always_comb begin
    col_nxt = col_cur + jhs_pkg::COL_W'(1);
    row_nxt = row_cur;
    if (last_col) begin
      col_nxt = '0;
      row_nxt = last_row ? '0 : (row_cur + jhs_pkg::ROW_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  assign item.temp          = in_ch.cell_temp;
  assign item.col           = col_cur;
  assign item.col0          = (col_cur == '0);
  assign item.last_col      = last_col;
  assign item.flags.is_edge = (row_cur == jhs_pkg::ROW_W'(1)) || (col_cur == '0) || last_col;
  assign item.flags.start   = in_ch.sweep_start;
  assign item.flags.last    = last_col && last_row;
  assign item.flags.emit    = (row_cur != '0);

  assign lb_req.load       = in_load;
  assign lb_req.acc        = in_acc;
  assign lb_req.col        = col_cur;
  assign lb_req.right_addr = col_cur + jhs_pkg::COL_W'(1);
  assign lb_req.temp       = in_ch.cell_temp;

  jhs_line_buffer u_lb (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (lb_req),
    .wr    (lb_wr),
    .rd    (lb_rd)
  );

  jhs_stencil_pipe u_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .coeff     (cfg.coeff),
    .in_acc    (in_acc),
    .in_item   (item),
    .in_load   (in_load),
    .rd        (lb_rd),
    .wr        (lb_wr),
    .out_load  (out_load),
    .res_valid (res_valid),
    .res       (res)
  );

  jhs_change_track u_track (
    .clk       (clk),
    .rst_n     (rst_n),
    .thresh    (cfg.thresh),
    .res_valid (res_valid),
    .res       (res),
    .out_load  (out_load),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

// File: rtl/jhs_cfg_regs.sv
// Configuration registers with range clamping.
// Depends on jhs_pkg and jhs_channels.
`timescale 1ns / 1ps
`default_nettype none

module jhs_cfg_regs (
  input  logic           clk,
  input  logic           rst_n,
  jhs_cfg_if.sink        cfg_ch,
  output jhs_pkg::cfg_t  cfg
);

  logic [jhs_pkg::COEF_W-1:0]     coeff_r;
  logic [jhs_pkg::THR_W-1:0]      thresh_r;
  logic [jhs_pkg::CFG_COLS_W-1:0] cols_r;
  logic [jhs_pkg::CFG_ROWS_W-1:0] rows_r;
  logic [jhs_pkg::CFG_COLS_W-1:0] cols_clamp;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coeff_r  <= jhs_pkg::COEFF_RST;
      thresh_r <= jhs_pkg::THRESH_RST;
      cols_r   <= jhs_pkg::COLS_RST;
      rows_r   <= jhs_pkg::ROWS_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        jhs_pkg::REG_COEFF:  coeff_r  <= cfg_ch.data[jhs_pkg::COEF_W-1:0];
        jhs_pkg::REG_THRESH: thresh_r <= cfg_ch.data[jhs_pkg::THR_W-1:0];
        jhs_pkg::REG_COLS:   cols_r   <= cfg_ch.data[jhs_pkg::CFG_COLS_W-1:0];
        jhs_pkg::REG_ROWS:   rows_r   <= cfg_ch.data[jhs_pkg::CFG_ROWS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    priority if (cols_r < jhs_pkg::COLS_MIN) begin
      cols_clamp = jhs_pkg::COLS_MIN;
    end else if (cols_r > jhs_pkg::COLS_MAX) begin
      cols_clamp = jhs_pkg::COLS_MAX;
    end else begin
      cols_clamp = cols_r;
    end
  end

  assign cfg.coeff  = (coeff_r > jhs_pkg::COEFF_MAX) ? jhs_pkg::COEFF_MAX : coeff_r;
  assign cfg.thresh = thresh_r;
  assign cfg.cols   = jhs_pkg::CNT_W'(cols_clamp);
  assign cfg.rows   = (rows_r < jhs_pkg::ROWS_MIN) ? jhs_pkg::ROWS_MIN : rows_r;

endmodule

`default_nettype wire

// File: rtl/jhs_line_buffer.sv
// Two line stores (row above, row two above) with registered reads and
// forwarding of the delayed row-two-above write. Depends on jhs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jhs_line_buffer (
  input  logic             clk,
  input  logic             rst_n,
  input  jhs_pkg::lb_req_t req,
  input  jhs_pkg::lb_wr_t  wr,
  output jhs_pkg::lb_rd_t  rd
);

  jhs_pkg::temp_t above_mem [jhs_pkg::MAX_COLUMNS];
  jhs_pkg::temp_t two_mem   [jhs_pkg::MAX_COLUMNS];

  jhs_pkg::temp_t centre0_q;
  jhs_pkg::temp_t right_q;
  jhs_pkg::temp_t above2_q;
  jhs_pkg::temp_t fwd_data_r;
  logic           fwd_r;

  always_ff @(posedge clk) begin
    if (req.load) begin
      centre0_q  <= above_mem[0];
      right_q    <= above_mem[req.right_addr];
      above2_q   <= two_mem[req.col];
      fwd_data_r <= wr.data;
    end
    if (req.acc) begin
      above_mem[req.col] <= req.temp;
    end
    if (wr.en) begin
      two_mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else if (req.load) begin
      fwd_r <= wr.en && (wr.addr == req.col);
    end
  end

  assign rd.centre0 = centre0_q;
  assign rd.right   = right_q;
  assign rd.above2  = fwd_r ? fwd_data_r : above2_q;

endmodule

`default_nettype wire

// File: rtl/jhs_stencil_pipe.sv
// Stencil datapath: window, neighbour sum, two products, rounding and
// saturation over four stages with per-stage stall. Depends on jhs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jhs_stencil_pipe (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [jhs_pkg::COEF_W-1:0] coeff,
  input  logic                       in_acc,
  input  jhs_pkg::item_t             in_item,
  output logic                       in_load,
  input  jhs_pkg::lb_rd_t            rd,
  output jhs_pkg::lb_wr_t            wr,
  input  logic                       out_load,
  output logic                       res_valid,
  output jhs_pkg::res_t              res
);

  logic                       s1_v_r, s2_v_r, s3_v_r, s4_v_r;
  logic                       load_s2, load_s3, load_s4;
  jhs_pkg::item_t             s1_r;
  jhs_pkg::temp_t             win_left_r, win_centre_r;
  jhs_pkg::temp_t             centre, right;
  logic [jhs_pkg::SUM_W-1:0]  sum;
  logic                       adv1;

  logic [jhs_pkg::SUM_W-1:0]  s2_sum_r;
  jhs_pkg::temp_t             s2_centre_r;
  jhs_pkg::flags_t            s2_flags_r;
  logic [jhs_pkg::KC_W-1:0]   kc;

  logic [jhs_pkg::P1_W-1:0]   s3_p1_r;
  logic [jhs_pkg::P2_W-1:0]   s3_p2_r;
  jhs_pkg::temp_t             s3_centre_r;
  jhs_pkg::flags_t            s3_flags_r;
  logic [jhs_pkg::ACC_W-1:0]  acc;
  logic [jhs_pkg::V_W-1:0]    v;
  jhs_pkg::temp_t             v_sat;

  jhs_pkg::res_t              s4_r;

  assign load_s4 = !s4_v_r || out_load;
  assign load_s3 = !s3_v_r || load_s4;
  assign load_s2 = !s2_v_r || load_s3;
  assign in_load = !s1_v_r || load_s2;
  assign adv1    = s1_v_r && load_s2;

  // window and neighbour sum
  assign centre = s1_r.col0 ? rd.centre0 : win_centre_r;
  assign right  = s1_r.last_col ? '0 : rd.right;
  assign sum    = jhs_pkg::SUM_W'(rd.above2) + jhs_pkg::SUM_W'(s1_r.temp)
                + jhs_pkg::SUM_W'(win_left_r) + jhs_pkg::SUM_W'(right);

  assign wr.en   = adv1;
  assign wr.addr = s1_r.col;
  assign wr.data = centre;

  assign kc = jhs_pkg::KC_ONE - (jhs_pkg::KC_W'(coeff) << 2);

  assign acc   = jhs_pkg::ACC_W'(s3_p1_r) + jhs_pkg::ACC_W'(s3_p2_r) + jhs_pkg::ROUND_HALF;
  assign v     = acc[jhs_pkg::ACC_W-1:jhs_pkg::FRAC_BITS];
  assign v_sat = (v > jhs_pkg::V_W'(jhs_pkg::TEMP_MAX)) ? jhs_pkg::TEMP_MAX
                                                        : v[jhs_pkg::TEMP_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r       <= 1'b0;
      s2_v_r       <= 1'b0;
      s3_v_r       <= 1'b0;
      s4_v_r       <= 1'b0;
      win_left_r   <= '0;
      win_centre_r <= '0;
    end else begin
      if (in_load) s1_v_r <= in_acc;
      if (load_s2) s2_v_r <= s1_v_r;
      if (load_s3) s3_v_r <= s2_v_r;
      if (load_s4) s4_v_r <= s3_v_r;
      if (adv1) begin
        win_left_r   <= centre;
        win_centre_r <= right;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      s1_r <= in_item;
    end
    if (load_s2) begin
      s2_sum_r    <= sum;
      s2_centre_r <= centre;
      s2_flags_r  <= s1_r.flags;
    end
    if (load_s3) begin
      s3_p1_r     <= jhs_pkg::P1_W'(s2_sum_r) * jhs_pkg::P1_W'(coeff);
      s3_p2_r     <= jhs_pkg::P2_W'(s2_centre_r) * jhs_pkg::P2_W'(kc);
      s3_centre_r <= s2_centre_r;
      s3_flags_r  <= s2_flags_r;
    end
    if (load_s4) begin
      s4_r.val    <= s3_flags_r.is_edge ? s3_centre_r : v_sat;
      s4_r.centre <= s3_centre_r;
      s4_r.flags  <= s3_flags_r;
    end
  end

  assign res_valid = s4_v_r;
  assign res       = s4_r;

endmodule

`default_nettype wire

// File: rtl/jhs_change_track.sv
// Change tracking and output register: running maximum of |new - old|,
// convergence flag and the result channel. Depends on jhs_pkg, jhs_channels.
`timescale 1ns / 1ps
`default_nettype none

module jhs_change_track (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [jhs_pkg::THR_W-1:0] thresh,
  input  logic                      res_valid,
  input  jhs_pkg::res_t             res,
  output logic                      out_load,
  jhs_out_if.source                 out_ch
);

  logic           out_v_r;
  jhs_pkg::temp_t out_temp_r;
  logic           out_last_r;
  jhs_pkg::temp_t out_max_r;
  logic           out_settled_r;
  jhs_pkg::temp_t max_r, max_nxt;
  jhs_pkg::temp_t diff, base;
  logic           adv;

  assign out_load = !out_v_r || out_ch.ready;
  assign adv      = res_valid && out_load;

  assign diff    = (res.val >= res.centre) ? (res.val - res.centre) : (res.centre - res.val);
  assign base    = res.flags.start ? '0 : max_r;
  assign max_nxt = (res.flags.emit && (diff > base)) ? diff : base;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      max_r   <= '0;
    end else begin
      if (out_load) out_v_r <= res_valid && res.flags.emit;
      if (adv) max_r <= res.flags.last ? '0 : max_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_temp_r    <= res.val;
      out_last_r    <= res.flags.last;
      out_max_r     <= max_nxt;
      out_settled_r <= res.flags.last && (jhs_pkg::THR_W'(max_nxt) <= thresh);
    end
  end

  assign out_ch.valid          = out_v_r;
  assign out_ch.new_temp       = out_temp_r;
  assign out_ch.sweep_last     = out_last_r;
  assign out_ch.largest_change = out_max_r;
  assign out_ch.settled        = out_settled_r;

endmodule

`default_nettype wire

// File: rtl/jhs_checker.sv
// Port-level checker for the Jacobi heat stencil sweep core, bound to the
// top level. Depends on jhs_pkg and jacobi_heat_stencil_sweep_core_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "jacobi_heat_stencil_sweep_core_defines.svh"

module jhs_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input jhs_pkg::temp_t out_new_temp,
  input logic           out_sweep_last,
  input jhs_pkg::temp_t out_largest_change,
  input logic           out_settled,
  input logic           cfg_valid,
  input logic           cfg_ready
);

  logic in_seen;
  assign in_seen = in_valid || !in_valid;

  // the input side only backs up behind a held result
  `JHS_ASSERT_NOW(a_ready_when_empty, clk, rst_n, in_seen && !out_valid, in_ready)

  // convergence is reported only on the last result of a sweep
  `JHS_ASSERT_NOW(a_settled_on_last, clk, rst_n, out_valid && out_settled, out_sweep_last)

  // hold a stalled result
  `JHS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_new_temp) && $stable(out_largest_change) && $stable(out_sweep_last) && $stable(out_settled))

  // configuration writes never wait
  `JHS_ASSERT_NOW(a_cfg_ready, clk, rst_n, cfg_valid, cfg_ready)

endmodule

bind jacobi_heat_stencil_sweep_core jhs_checker u_jhs_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_ch.valid),
  .in_ready           (in_ch.ready),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_new_temp       (out_ch.new_temp),
  .out_sweep_last     (out_ch.sweep_last),
  .out_largest_change (out_ch.largest_change),
  .out_settled        (out_ch.settled),
  .cfg_valid          (cfg_ch.valid),
  .cfg_ready          (cfg_ch.ready)
);

`default_nettype wire

// File: tb/jacobi_heat_stencil_sweep_core_tb.sv
// Self-checking testbench for the Jacobi heat stencil sweep core: a cell-level
// predictor checks every result, with directed, random and full-width sweeps.
// Depends on jhs_pkg, jhs_channels and the core RTL.
`timescale 1ns / 1ps

module jacobi_heat_stencil_sweep_core_tb;

  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned RANDOM_CELLS = 300;
  localparam int unsigned WIDE_CELLS   = jhs_pkg::MAX_COLUMNS + 160;
  localparam logic [jhs_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = jhs_pkg::CFG_IDX_W'(12);

  typedef struct packed {
    jhs_pkg::temp_t new_temp;
    logic           sweep_last;
    jhs_pkg::temp_t largest_change;
    logic           settled;
  } heat_result_t;

  typedef enum int {FILL_FLAT, FILL_NOISE, FILL_RAMP, FILL_EXTREME, FILL_RANDOM} fill_t;
  typedef enum int {RX_ALWAYS, RX_SPARSE, RX_PATTERN, RX_HEAVY} stall_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  jhs_in_if  in_ch ();
  jhs_out_if out_ch ();
  jhs_cfg_if cfg_ch ();

  jacobi_heat_stencil_sweep_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #6 clk = ~clk;

  jhs_pkg::temp_t    line_above     [jhs_pkg::MAX_COLUMNS];
  jhs_pkg::temp_t    line_two_above [jhs_pkg::MAX_COLUMNS];
  jhs_pkg::temp_t    win_left;
  jhs_pkg::temp_t    win_centre;
  int unsigned       col_pos;
  logic [jhs_pkg::ROW_W-1:0]      row_pos;
  jhs_pkg::temp_t                 peak_change;
  logic [jhs_pkg::COEF_W-1:0]     coeff_reg;
  logic [jhs_pkg::THR_W-1:0]      thresh_reg;
  logic [jhs_pkg::CFG_COLS_W-1:0] cols_reg;
  logic [jhs_pkg::CFG_ROWS_W-1:0] rows_reg;
  heat_result_t      pending_cells [$];

  int unsigned mismatches = 0;
  int unsigned results_checked = 0;
  int unsigned sweeps_closed = 0;
  int unsigned settled_seen = 0;
  int unsigned cells_sent = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;
  logic        gaps_on = 1'b1;
  stall_t      stall_style = RX_ALWAYS;

  function automatic int unsigned grid_width();
    if (cols_reg < jhs_pkg::COLS_MIN) return jhs_pkg::COLS_MIN;
    if (cols_reg > jhs_pkg::COLS_MAX) return jhs_pkg::COLS_MAX;
    return cols_reg;
  endfunction

  function automatic int unsigned grid_height();
    if (rows_reg < jhs_pkg::ROWS_MIN) return jhs_pkg::ROWS_MIN;
    return rows_reg;
  endfunction

  function automatic void relax_cell(input jhs_pkg::temp_t cell_val, input logic start);
    int unsigned     width, height, r;
    logic            last_col, last_row, border;
    jhs_pkg::temp_t  centre, right, above2, val, diff;
    longint unsigned acc, rounded;
    heat_result_t    res;
    width = grid_width();
    height = grid_height();
    r = (coeff_reg > jhs_pkg::COEFF_MAX) ? jhs_pkg::COEFF_MAX : coeff_reg;
    if (start) begin
      col_pos = 0;
      row_pos = '0;
      peak_change = '0;
    end
    last_col = (col_pos + 1 >= width);
    last_row = (row_pos + 1 >= height);
    centre = (col_pos == 0) ? line_above[col_pos] : win_centre;
    right = last_col ? '0 : line_above[col_pos + 1];
    above2 = line_two_above[col_pos];
    if (row_pos >= 1) begin
      border = (row_pos == 1) || (col_pos == 0) || last_col;
      acc = (64'(above2) + 64'(cell_val) + 64'(win_left) + 64'(right)) * 64'(r)
          + 64'(centre) * (64'(65536) - 64'(4 * r));
      rounded = (acc + 64'(32768)) >> 16;
      if (border) val = centre;
      else if (rounded > 64'(jhs_pkg::TEMP_MAX)) val = jhs_pkg::TEMP_MAX;
      else val = jhs_pkg::temp_t'(rounded);
      diff = (val > centre) ? val - centre : centre - val;
      if (diff > peak_change) peak_change = diff;
      res.new_temp = val;
      res.sweep_last = last_col && last_row;
      res.largest_change = peak_change;
      res.settled = last_col && last_row && (peak_change <= thresh_reg);
      pending_cells.push_back(res);
    end
    win_left = centre;
    win_centre = right;
    line_two_above[col_pos] = line_above[col_pos];
    line_above[col_pos] = cell_val;
    if (last_col) begin
      col_pos = 0;
      if (last_row) begin
        row_pos = '0;
        peak_change = '0;
      end else begin
        row_pos = row_pos + 1'b1;
      end
    end else begin
      col_pos = col_pos + 1;
    end
  endfunction

  task automatic send_cell(input jhs_pkg::temp_t cell_val, input logic start);
    if (gaps_on) begin
      if (burst_left == 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        burst_left = $urandom_range(1, 16);
      end
      burst_left--;
    end
    in_ch.valid <= 1'b1;
    in_ch.cell_temp <= cell_val;
    in_ch.sweep_start <= start;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    relax_cell(cell_val, start);
    cells_sent++;
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_cells.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [jhs_pkg::CFG_IDX_W-1:0] idx,
                           input logic [jhs_pkg::CFG_DATA_W-1:0] value,
                           input logic closing);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      jhs_pkg::REG_COEFF:  coeff_reg = value[jhs_pkg::COEF_W-1:0];
      jhs_pkg::REG_THRESH: thresh_reg = value[jhs_pkg::THR_W-1:0];
      jhs_pkg::REG_COLS:   cols_reg = value[jhs_pkg::CFG_COLS_W-1:0];
      jhs_pkg::REG_ROWS:   rows_reg = value[jhs_pkg::CFG_ROWS_W-1:0];
      default: ;
    endcase
    if (closing) cfg_ch.valid <= 1'b0;
  endtask

  task automatic run_sweep(input fill_t fill, input logic mark_start,
                           input int unsigned stop_after);
    int unsigned    total, count, spread, step, pause_at;
    jhs_pkg::temp_t base, cell_val;
    total = grid_width() * grid_height();
    if (stop_after != 0 && stop_after < total) total = stop_after;
    base = jhs_pkg::temp_t'($urandom);
    spread = 1 << $urandom_range(0, 12);
    step = $urandom_range(0, 4096);
    pause_at = ($urandom_range(0, 9) == 0) ? $urandom_range(1, total - 1) : 0;
    gaps_on = ($urandom_range(0, 3) != 0);
    for (count = 0; count < total; count++) begin
      case (fill)
        FILL_FLAT:    cell_val = base;
        FILL_NOISE:   cell_val = base ^ jhs_pkg::temp_t'($urandom_range(0, spread));
        FILL_RAMP:    cell_val = base + jhs_pkg::temp_t'(step * count);
        FILL_EXTREME: cell_val = $urandom_range(0, 1) ? jhs_pkg::TEMP_MAX : '0;
        default:      cell_val = jhs_pkg::temp_t'($urandom);
      endcase
      if (pause_at != 0 && count == pause_at) drain_results();
      send_cell(cell_val, mark_start && count == 0);
    end
  endtask

  task automatic test_edges_and_reset_coeff();
    int unsigned i;
    write_reg(jhs_pkg::REG_COLS, jhs_pkg::CFG_DATA_W'(0), 1'b0);
    write_reg(jhs_pkg::REG_ROWS, jhs_pkg::CFG_DATA_W'(1), 1'b0);
    write_reg(REG_UNMAPPED, '1, 1'b1);
    for (i = 0; i < 9; i++) send_cell((i % 2) ? jhs_pkg::TEMP_MAX : '0, i == 0);
    drain_results();
  endtask

  task automatic test_wrap_and_coeff_clamp();
    int unsigned i;
    write_reg(jhs_pkg::REG_COEFF, '1, 1'b0);
    write_reg(jhs_pkg::REG_THRESH, '1, 1'b1);
    for (i = 0; i < 9; i++) send_cell(jhs_pkg::temp_t'($urandom), 1'b0);
    drain_results();
  endtask

  task automatic test_resize_mid_sweep();
    int unsigned i;
    write_reg(jhs_pkg::REG_COLS, jhs_pkg::CFG_DATA_W'(4), 1'b0);
    write_reg(jhs_pkg::REG_ROWS, '1, 1'b1);
    for (i = 0; i < 11; i++) send_cell(jhs_pkg::temp_t'($urandom), i == 0);
    drain_results();
    // shrink both bounds under the live counters: the next cell closes the sweep
    write_reg(jhs_pkg::REG_COLS, jhs_pkg::CFG_DATA_W'(3), 1'b0);
    write_reg(jhs_pkg::REG_ROWS, jhs_pkg::CFG_DATA_W'(3), 1'b1);
    send_cell(jhs_pkg::temp_t'($urandom), 1'b0);
    drain_results();
  endtask

  task automatic test_random_sweeps();
    int unsigned                   first_cell, sweeps, k, cut;
    logic [jhs_pkg::CFG_DATA_W-1:0] coeff_val, thresh_val, cols_val;
    first_cell = cells_sent;
    while (cells_sent - first_cell < RANDOM_CELLS) begin
      drain_results();
      case ($urandom_range(0, 4))
        0:       coeff_val = '0;
        1:       coeff_val = jhs_pkg::CFG_DATA_W'(jhs_pkg::COEFF_MAX);
        2:       coeff_val = jhs_pkg::CFG_DATA_W'($urandom_range(16385, 32767));
        3:       coeff_val = jhs_pkg::CFG_DATA_W'($urandom);
        default: coeff_val = jhs_pkg::CFG_DATA_W'($urandom_range(0, 16384));
      endcase
      case ($urandom_range(0, 3))
        0:       thresh_val = '0;
        1:       thresh_val = jhs_pkg::CFG_DATA_W'($urandom_range(0, 255));
        2:       thresh_val = jhs_pkg::CFG_DATA_W'($urandom);
        default: thresh_val = jhs_pkg::CFG_DATA_W'($urandom_range(0, 65535));
      endcase
      if ($urandom_range(0, 4) == 0) begin
        cols_val = jhs_pkg::CFG_DATA_W'($urandom_range(0, 2));
      end else if ($urandom_range(0, 9) == 0) begin
        cols_val = jhs_pkg::CFG_DATA_W'($urandom_range(11, 40));
      end else begin
        cols_val = jhs_pkg::CFG_DATA_W'($urandom_range(3, 10));
      end
      write_reg(jhs_pkg::REG_COEFF, coeff_val, 1'b0);
      write_reg(jhs_pkg::REG_THRESH, thresh_val, 1'b0);
      write_reg(jhs_pkg::REG_COLS, cols_val, 1'b0);
      write_reg(jhs_pkg::REG_ROWS, jhs_pkg::CFG_DATA_W'($urandom_range(0, 7)), 1'b1);
      sweeps = $urandom_range(1, 3);
      for (k = 0; k < sweeps; k++) begin
        if ($urandom_range(0, 7) == 0) begin
          // cut the sweep somewhere after its first row, restart with sweep_start
          cut = $urandom_range(grid_width(), grid_width() * grid_height() - 1);
          run_sweep(fill_t'($urandom_range(0, 4)), $urandom_range(0, 1), cut);
          run_sweep(fill_t'($urandom_range(0, 4)), 1'b1, 0);
        end else begin
          run_sweep(fill_t'($urandom_range(0, 4)), $urandom_range(0, 1), 0);
        end
      end
    end
    drain_results();
  endtask

  task automatic test_widest_grid();
    write_reg(jhs_pkg::REG_COEFF, jhs_pkg::CFG_DATA_W'($urandom_range(0, 16384)), 1'b0);
    write_reg(jhs_pkg::REG_THRESH, jhs_pkg::CFG_DATA_W'($urandom_range(0, 4095)), 1'b0);
    write_reg(jhs_pkg::REG_COLS, '1, 1'b0);
    write_reg(jhs_pkg::REG_ROWS, jhs_pkg::CFG_DATA_W'(3), 1'b1);
    // fill every store entry, then stop early in the second row
    run_sweep(($urandom_range(0, 1) != 0) ? FILL_RAMP : FILL_NOISE, 1'b1, WIDE_CELLS);
    drain_results();
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count[7:0] == 8'd0) stall_style <= stall_t'($urandom_range(0, 3));
    case (stall_style)
      RX_ALWAYS:  out_ch.ready <= 1'b1;
      RX_SPARSE:  out_ch.ready <= ($urandom_range(0, 3) != 0);
      RX_PATTERN: out_ch.ready <= (cycle_count[2:0] < 3'd5);
      default:    out_ch.ready <= $urandom_range(0, 1);
    endcase
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[jacobi_heat_stencil_sweep_core] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin : check_results
    heat_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_cells.size() == 0) begin
        $error("unexpected transfer: new_temp %h", out_ch.new_temp);
        mismatches++;
      end else begin
        want = pending_cells.pop_front();
        if (out_ch.new_temp !== want.new_temp) begin
          $error("new_temp: expected %h, got %h", want.new_temp, out_ch.new_temp);
          mismatches++;
        end
        if (out_ch.sweep_last !== want.sweep_last) begin
          $error("sweep_last: expected %b, got %b", want.sweep_last, out_ch.sweep_last);
          mismatches++;
        end
        if (out_ch.largest_change !== want.largest_change) begin
          $error("largest_change: expected %h, got %h", want.largest_change,
                 out_ch.largest_change);
          mismatches++;
        end
        if (out_ch.settled !== want.settled) begin
          $error("settled: expected %b, got %b", want.settled, out_ch.settled);
          mismatches++;
        end
        results_checked++;
        if (want.sweep_last) sweeps_closed++;
        if (want.settled) settled_seen++;
      end
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.cell_temp = '0;
    in_ch.sweep_start = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    out_ch.ready = 1'b0;
    coeff_reg = jhs_pkg::COEFF_RST;
    thresh_reg = jhs_pkg::THRESH_RST;
    cols_reg = jhs_pkg::COLS_RST;
    rows_reg = jhs_pkg::ROWS_RST;
    win_left = '0;
    win_centre = '0;
    col_pos = 0;
    row_pos = '0;
    peak_change = '0;
    foreach (line_above[i]) begin
      line_above[i] = '0;
      line_two_above[i] = '0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_edges_and_reset_coeff();
    test_wrap_and_coeff_clamp();
    test_resize_mid_sweep();
    test_random_sweeps();
    test_widest_grid();
    drain_results();
    $display("Streamed %0d cells over grids 3 to 1024 wide, %0d updated cells checked",
             cells_sent, results_checked);
    $display("%0d sweeps closed (%0d settled) across coefficient, threshold and size changes",
             sweeps_closed, settled_seen);
    if (mismatches == 0) begin
      $display("[jacobi_heat_stencil_sweep_core] OK");
    end else begin
      $display("[jacobi_heat_stencil_sweep_core] ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/jhs_pkg.sv
rtl/jhs_channels.sv
rtl/jhs_cfg_regs.sv
rtl/jhs_line_buffer.sv
rtl/jhs_stencil_pipe.sv
rtl/jhs_change_track.sv
rtl/jacobi_heat_stencil_sweep_core.sv
rtl/jhs_checker.sv
tb/jacobi_heat_stencil_sweep_core_tb.sv
